// ----- design/cgc_pkg.sv -----
package cgc_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  localparam int CNT_W = 8;
  localparam int CFG_W = 16;
  localparam int BTN_W = 4;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd400;

  typedef enum logic [1:0] {
    GEST_SINGLE = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LONG   = 2'd2
  } gesture_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVENT,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic is_tick;
    logic is_press;
  } unit_cmd_t;

  typedef struct packed {
    logic     expire;
    gesture_t gesture;
  } unit_status_t;

endpackage

// ----- design/cgc_unit.sv -----
module cgc_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  cgc_pkg::unit_cmd_t           cmd,
  input  logic [cgc_pkg::CNT_W-1:0]    press_i,
  input  logic [cgc_pkg::CNT_W-1:0]    rel_i,
  input  logic [TIMER_WIDTH-1:0]       cd_i,
  input  logic [TIMER_WIDTH-1:0]       load_i,
  output logic [cgc_pkg::CNT_W-1:0]    press_o,
  output logic [cgc_pkg::CNT_W-1:0]    rel_o,
  output logic [TIMER_WIDTH-1:0]       cd_o,
  output cgc_pkg::unit_status_t        status
);

  localparam logic [cgc_pkg::CNT_W-1:0] CNT_MAX = {cgc_pkg::CNT_W{1'b1}};

  logic active;
  assign active = (press_i != '0);

  always_comb begin
    press_o        = press_i;
    rel_o          = rel_i;
    cd_o           = cd_i;
    status.expire  = 1'b0;
    status.gesture = cgc_pkg::GEST_SINGLE;
    if (cmd.is_tick) begin
      if (active) begin
        if (cd_i > TIMER_WIDTH'(1)) begin
          cd_o = cd_i - TIMER_WIDTH'(1);
        end else begin
          status.expire = 1'b1;
          if (rel_i == '0) begin
            status.gesture = cgc_pkg::GEST_LONG;
          end else if (press_i > cgc_pkg::CNT_W'(1)) begin
            status.gesture = cgc_pkg::GEST_DOUBLE;
          end else begin
            status.gesture = cgc_pkg::GEST_SINGLE;
          end
          press_o = '0;
          rel_o   = '0;
          cd_o    = '0;
        end
      end
    end else if (cmd.is_press) begin
      if (!active) begin
        rel_o = '0;
        cd_o  = load_i;
      end
      if (press_i != CNT_MAX) begin
        press_o = press_i + cgc_pkg::CNT_W'(1);
      end
    end else if (active && (rel_i != CNT_MAX)) begin
      rel_o = rel_i + cgc_pkg::CNT_W'(1);
    end
  end

endmodule

// ----- design/click_gesture_classifier_core.sv -----
// Button event: accepted in IDLE, state updated in the next (S_EVENT); ready again on return to IDLE.
// Tick: each button in turn through the shared update unit (S_SCAN), then a flush state (S_FLUSH);
// the scan holds while an expiring button finds a pending result that cannot move to the output.
// Tick results wait in one pending register and move to the output register at the scan of the
// next expiring button or at flush; the result moved at flush is flagged with out_last.
// rst_n is synchronous, active low: all counts and timers clear, window returns to 400.
module click_gesture_classifier_core #(
  parameter int NUM_BUTTONS = 4,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [cgc_pkg::BTN_W-1:0]   in_button,
  input  logic                        in_is_press,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cgc_pkg::BTN_W-1:0]   out_button_id,
  output logic [1:0]                  out_gesture,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cgc_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int LW = (TIMER_WIDTH > cgc_pkg::CFG_W) ? TIMER_WIDTH : cgc_pkg::CFG_W;
  localparam logic [LW-1:0] TMAX = LW'({TIMER_WIDTH{1'b1}});

  cgc_pkg::state_t state_r, state_nxt;

  logic [cgc_pkg::CFG_W-1:0] window_r;
  logic                      op_r;
  logic [cgc_pkg::BTN_W-1:0] btn_r;
  logic                      press_r;
  logic [IW-1:0]             scan_r, scan_nxt;

  logic [cgc_pkg::CNT_W-1:0] press_cnt_r [NUM_BUTTONS];
  logic [cgc_pkg::CNT_W-1:0] rel_cnt_r   [NUM_BUTTONS];
  logic [TIMER_WIDTH-1:0]    cd_r        [NUM_BUTTONS];

  logic                      pend_vld_r, pend_vld_nxt;
  logic [cgc_pkg::BTN_W-1:0] pend_bid_r;
  cgc_pkg::gesture_t         pend_gest_r;

  logic                      out_valid_r;
  logic [cgc_pkg::BTN_W-1:0] out_bid_r;
  cgc_pkg::gesture_t         out_gest_r;
  logic                      out_last_r;

  logic btn_ok;
  logic [IW-1:0] sel;
  logic out_free;
  logic wr_en;
  logic pend_load;
  logic out_load;
  logic out_load_last;
  logic scan_done;

  logic [LW-1:0]          win_ext;
  logic [TIMER_WIDTH-1:0] load_val;

  cgc_pkg::unit_cmd_t        cmd;
  cgc_pkg::unit_status_t     status;
  logic [cgc_pkg::CNT_W-1:0] press_new, rel_new;
  logic [TIMER_WIDTH-1:0]    cd_new;

  assign in_ready      = (state_r == cgc_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_button_id = out_bid_r;
  assign out_gesture   = out_gest_r;
  assign out_last      = out_last_r;

  assign btn_ok    = ({1'b0, btn_r} < (cgc_pkg::BTN_W + 1)'(NUM_BUTTONS));
  assign sel       = (state_r == cgc_pkg::S_EVENT) ? btn_r[IW-1:0] : scan_r;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (scan_r == IW'(NUM_BUTTONS - 1));

  always_comb begin
    win_ext = LW'(window_r);
    if (win_ext > TMAX) begin
      win_ext = TMAX;
    end
    if (win_ext == '0) begin
      win_ext = LW'(1);
    end
    load_val = win_ext[TIMER_WIDTH-1:0];
  end

  assign cmd.is_tick  = (op_r == cgc_pkg::OP_TICK);
  assign cmd.is_press = press_r;

  cgc_unit #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_unit (
    .cmd     (cmd),
    .press_i (press_cnt_r[sel]),
    .rel_i   (rel_cnt_r[sel]),
    .cd_i    (cd_r[sel]),
    .load_i  (load_val),
    .press_o (press_new),
    .rel_o   (rel_new),
    .cd_o    (cd_new),
    .status  (status)
  );

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    case (state_r)
      cgc_pkg::S_IDLE: begin
        scan_nxt = '0;
        if (in_valid) begin
          state_nxt = (in_operation == cgc_pkg::OP_TICK) ? cgc_pkg::S_SCAN : cgc_pkg::S_EVENT;
        end
      end
      cgc_pkg::S_EVENT: begin
        state_nxt = cgc_pkg::S_IDLE;
      end
      cgc_pkg::S_SCAN: begin
        if (wr_en) begin
          if (scan_done) begin
            state_nxt = cgc_pkg::S_FLUSH;
          end else begin
            scan_nxt = scan_r + IW'(1);
          end
        end
      end
      cgc_pkg::S_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = cgc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cgc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    wr_en         = 1'b0;
    pend_load     = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    pend_vld_nxt  = pend_vld_r;
    case (state_r)
      cgc_pkg::S_EVENT: begin
        wr_en = btn_ok;
      end
      cgc_pkg::S_SCAN: begin
        if (!(status.expire && pend_vld_r && !out_free)) begin
          wr_en = 1'b1;
          if (status.expire) begin
            pend_load    = 1'b1;
            out_load     = pend_vld_r;
            pend_vld_nxt = 1'b1;
          end
        end
      end
      cgc_pkg::S_FLUSH: begin
        if (pend_vld_r && out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          pend_vld_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgc_pkg::S_IDLE;
      scan_r      <= '0;
      window_r    <= cgc_pkg::WINDOW_RESET;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_cnt_r[i] <= '0;
        rel_cnt_r[i]   <= '0;
        cd_r[i]        <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      scan_r     <= scan_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
      if (wr_en) begin
        press_cnt_r[sel] <= press_new;
        rel_cnt_r[sel]   <= rel_new;
        cd_r[sel]        <= cd_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      btn_r   <= in_button;
      press_r <= in_is_press;
    end
    if (out_load) begin
      out_bid_r  <= pend_bid_r;
      out_gest_r <= pend_gest_r;
      out_last_r <= out_load_last;
    end
    if (pend_load) begin
      pend_bid_r  <= cgc_pkg::BTN_W'(scan_r);
      pend_gest_r <= status.gesture;
    end
  end

endmodule
